@@ src/debounced_menu_navigator_top_macros.svh @@
// Assertion macros used by the checker file of the menu navigator.
`ifndef DEBOUNCED_MENU_NAVIGATOR_TOP_MACROS_SVH
`define DEBOUNCED_MENU_NAVIGATOR_TOP_MACROS_SVH

// Property checked at every rising edge of clk while out of reset.
`define DMN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked at every rising edge, overlapping form.
`define DMN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define DMN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/dmn_pkg.sv @@
package dmn_pkg;

	// Menu geometry and counter widths.
	localparam int MAX_ITEMS    = 16;
	localparam int SEL_W        = 4;
	localparam int COUNT_W      = 5;
	localparam int ELAPSED_BITS = 11;
	localparam int TICK_W       = 10;
	localparam int NUM_BUTTONS  = 3;

	// Button order inside the input word.
	localparam int BTN_UP     = 0;
	localparam int BTN_DOWN   = 1;
	localparam int BTN_SELECT = 2;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_HOLDOFF  = 2'd1;
	localparam logic [1:0] REG_COUNT    = 2'd2;

	// Reset values of the registers.
	localparam logic [TICK_W-1:0]  DEBOUNCE_RST = 10'd50;
	localparam logic [TICK_W-1:0]  HOLDOFF_RST  = 10'd150;
	localparam logic [COUNT_W-1:0] COUNT_RST    = 5'd8;

	// Word widths on the streams.
	localparam int IN_W  = 8;
	localparam int OUT_W = 16;

	typedef struct packed {
		logic [TICK_W-1:0]  debounce_ticks;
		logic [TICK_W-1:0]  nav_holdoff_ticks;
		logic [COUNT_W-1:0] menu_count;
	} cfg_t;

	typedef struct packed {
		logic             select_pulse;
		logic             moved;
		logic [SEL_W-1:0] window_top;
		logic [SEL_W-1:0] selected_item;
	} result_t;

endpackage

@@ src/dmn_core.sv @@
module dmn_core
	import dmn_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   tick,
	input  logic [NUM_BUTTONS-1:0] levels,
	output result_t                res
);

	localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = {ELAPSED_BITS{1'b1}};

	logic [NUM_BUTTONS-1:0]  last_level_q;
	logic [ELAPSED_BITS-1:0] stable_q [NUM_BUTTONS];
	logic [ELAPSED_BITS-1:0] holdoff_q;
	logic [SEL_W-1:0]        sel_q;
	logic [SEL_W-1:0]        top_q;

	logic [ELAPSED_BITS-1:0] stable_d [NUM_BUTTONS];
	logic [ELAPSED_BITS-1:0] holdoff_inc;
	logic [ELAPSED_BITS-1:0] holdoff_d;
	logic [NUM_BUTTONS-1:0]  pressed;
	logic [COUNT_W-1:0]      count;
	logic [COUNT_W-1:0]      max_top;
	logic                    gate;
	logic                    do_up;
	logic                    do_down;
	logic                    do_sel;
	logic                    moved;
	logic [SEL_W-1:0]        sel_a;
	logic [COUNT_W-1:0]      sel_b;
	logic [SEL_W-1:0]        sel_d;
	logic [SEL_W-1:0]        top_f;
	logic [SEL_W-1:0]        top_d;

	// Debounce: each elapsed count saturates and restarts on a level change.
	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (levels[i] != last_level_q[i]) begin
				stable_d[i] = '0;
			end else if (stable_q[i] == ELAPSED_MAX) begin
				stable_d[i] = ELAPSED_MAX;
			end else begin
				stable_d[i] = stable_q[i] + 1'b1;
			end
			pressed[i] = levels[i] &&
				(stable_d[i] > {{(ELAPSED_BITS-TICK_W){1'b0}}, cfg.debounce_ticks});
		end
	end

	// Clamp the menu size to 1..MAX_ITEMS and derive the last window line.
	always_comb begin
		if (cfg.menu_count == '0) begin
			count = COUNT_W'(1);
		end else if (cfg.menu_count > COUNT_W'(MAX_ITEMS)) begin
			count = COUNT_W'(MAX_ITEMS);
		end else begin
			count = cfg.menu_count;
		end
		max_top = (count >= COUNT_W'(2)) ? count - COUNT_W'(2) : '0;
	end

	// Holdoff gate, evaluated once per tick after the count advances.
	assign holdoff_inc = (holdoff_q == ELAPSED_MAX) ? ELAPSED_MAX : holdoff_q + 1'b1;
	assign gate = holdoff_inc >= {{(ELAPSED_BITS-TICK_W){1'b0}}, cfg.nav_holdoff_ticks};
	assign do_up   = gate && pressed[BTN_UP];
	assign do_down = gate && pressed[BTN_DOWN];
	assign do_sel  = gate && pressed[BTN_SELECT];
	assign moved   = do_up || do_down;
	assign holdoff_d = (moved || do_sel) ? '0 : holdoff_inc;

	// Selection: up first, then down, each with wraparound.
	always_comb begin
		if (do_up) begin
			sel_a = (sel_q != '0) ? sel_q - 1'b1 : SEL_W'(count - 1'b1);
		end else begin
			sel_a = sel_q;
		end
		sel_b = {1'b0, sel_a} + 1'b1;
		if (do_down) begin
			sel_d = (sel_b >= count) ? '0 : sel_b[SEL_W-1:0];
		end else begin
			sel_d = sel_a;
		end
	end

	// Window follows the selection, then is clamped to the last full pair.
	always_comb begin
		if (sel_d < top_q) begin
			top_f = sel_d;
		end else if ({1'b0, sel_d} > {1'b0, top_q} + 1'b1) begin
			top_f = sel_d - 1'b1;
		end else begin
			top_f = top_q;
		end
		if (!moved) begin
			top_d = top_q;
		end else if ({1'b0, top_f} > max_top) begin
			top_d = max_top[SEL_W-1:0];
		end else begin
			top_d = top_f;
		end
	end

	// State advances once per accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				stable_q[i] <= '0;
			end
			holdoff_q <= '0;
			sel_q     <= '0;
			top_q     <= '0;
		end else if (tick) begin
			last_level_q <= levels;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				stable_q[i] <= stable_d[i];
			end
			holdoff_q <= holdoff_d;
			sel_q     <= sel_d;
			top_q     <= top_d;
		end
	end

	assign res.selected_item = sel_d;
	assign res.window_top    = top_d;
	assign res.moved         = moved;
	assign res.select_pulse  = do_sel;

endmodule

@@ src/debounced_menu_navigator_top.sv @@
// Debounced menu navigator.
// Input stream: one word per millisecond tick carrying the raw up, down and
// select levels. Output stream: one word per input word with the selected
// menu index, the first visible line of a two-line window, a moved flag and
// a one-tick select pulse.
// A word accepted at an edge has its result registered in the output register,
// or in the skid register while stalled, and offered on m_tvalid. Throughput is
// one word per cycle while s_tready is high; the debounce, holdoff and wraparound
// logic is a single pass between the accepting edge and the output register.
// When the receiver stalls, a second result is parked in a skid register and
// s_tready drops only once both the output and skid registers are full.
// Reset clears the debounce counters, the holdoff (navigation stays blocked
// for the first nav_holdoff_ticks-1 words afterwards), the selection and the window, and
// loads the registers with 50, 150 and 8.
// Configuration goes through the APB port: debounce_ticks at 0x0,
// nav_holdoff_ticks at 0x4, menu_count at 0x8. Write only while idle.
module debounced_menu_navigator_top
	import dmn_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// APB configuration port
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// Input stream
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // [0] up_level, [1] down_level, [2] select_level
	// Output stream
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // [3:0] selected_item, [7:4] window_top,
	                                    // [8] moved, [9] select_pulse
);

	cfg_t    cfg_q;
	result_t res;
	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	logic    in_acc;
	logic    cfg_wr;
	logic    out_load;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks    <= DEBOUNCE_RST;
			cfg_q.nav_holdoff_ticks <= HOLDOFF_RST;
			cfg_q.menu_count        <= COUNT_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_DEBOUNCE: cfg_q.debounce_ticks    <= pwdata[TICK_W-1:0];
				REG_HOLDOFF:  cfg_q.nav_holdoff_ticks <= pwdata[TICK_W-1:0];
				REG_COUNT:    cfg_q.menu_count        <= pwdata[COUNT_W-1:0];
				default:      ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (paddr[3:2])
			REG_DEBOUNCE: prdata = {{(32-TICK_W){1'b0}}, cfg_q.debounce_ticks};
			REG_HOLDOFF:  prdata = {{(32-TICK_W){1'b0}}, cfg_q.nav_holdoff_ticks};
			REG_COUNT:    prdata = {{(32-COUNT_W){1'b0}}, cfg_q.menu_count};
			default:      prdata = '0;
		endcase
	end

	assign s_tready = !skid_valid_q;
	assign in_acc   = s_tvalid && s_tready;
	assign out_load = !out_valid_q || m_tready;

	dmn_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.tick   (in_acc),
		.levels (s_tdata[NUM_BUTTONS-1:0]),
		.res    (res)
	);

	// Valid bits of the output and skid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_load) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_acc;
			end
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Result payload: the skid word drains first to keep order.
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_acc) begin
				out_q <= res;
			end
		end else if (in_acc) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W-$bits(result_t)){1'b0}}, out_q};

endmodule

@@ src/dmn_checker.sv @@
`include "debounced_menu_navigator_top_macros.svh"

module dmn_checker
	import dmn_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// A stalled result stays offered.
	`DMN_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped while stalled")

	// A stalled result keeps its value.
	`DMN_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata), "m_tdata changed while stalled")

	// Input back-pressure only appears with a result waiting at the output.
	`DMN_ASSERT_IMP(a_ready_full, !s_tready, m_tvalid, "s_tready low with empty output")

	// Padding above the result fields is always zero.
	`DMN_ASSERT_IMP(a_pad_zero, m_tvalid, m_tdata[OUT_W-1:10] == '0, "nonzero padding in m_tdata")

endmodule

bind debounced_menu_navigator_top dmn_checker u_dmn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
